### hw/rtl/ovar_pkg.sv
// Shared constants and types of the oversampled voltage readout.
package ovar_pkg;

  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned HUND_W    = 14;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET    = 16'd25176;
  localparam logic [HUND_W-1:0]  MAX_HUNDREDTHS = 14'd9999;
  localparam int unsigned        ROUND_HALF     = 32768;

  // Reciprocals for exact digit extraction on values below 10000, 1000 and 100.
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // >> 23
  localparam logic [5:0]  RECIP_100  = 6'd41;     // >> 12
  localparam logic [7:0]  RECIP_10   = 8'd205;    // >> 11

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  // Byte positions of one voltage line.
  typedef enum logic [2:0] {
    SLOT_TENS       = 3'd0,
    SLOT_ONES       = 3'd1,
    SLOT_POINT      = 3'd2,
    SLOT_TENTHS     = 3'd3,
    SLOT_HUNDREDTHS = 3'd4,
    SLOT_CR         = 3'd5,
    SLOT_LF         = 3'd6
  } slot_e;

endpackage

### hw/rtl/oversampled_voltage_ascii_readout_unit.sv
// Top level of the oversampled voltage readout with ASCII line output.
//
// Converter samples enter one beat per clock on the push/full side while
// full is low. Every OVERSAMPLE_COUNT samples are summed, the sum is shifted
// right by two to form one reading, and the reading goes into a small queue
// (FIFO_DEPTH entries). The back end multiplies the reading by volts_scale,
// rounds it to hundredths of a volt (clamped at 99.99), and sends seven byte
// beats on the empty/pop side: tens, ones, '.', tenths, hundredths, CR, LF,
// with line_end high on the LF beat. Digits are exact, taken one per byte
// from the integer count of hundredths. The byte side loads the sequencer,
// then sends the seven bytes of a reading. A reading passes the queue memory,
// the queue head, the product register and the sequencer before its first
// byte is registered at the output. full rises only when the reading queue is
// full, which happens when pop is held off or readings close faster than the
// bytes drain. Write volts_scale (cfg_we_i, cfg_data_i) only while idle.
module oversampled_voltage_ascii_readout_unit
  import ovar_pkg::*;
#(
  parameter int unsigned OVERSAMPLE_COUNT = 16,
  parameter int unsigned SAMPLE_BITS      = 10,
  parameter int unsigned FIFO_DEPTH       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   line_end_o,
  input  logic                   cfg_we_i,
  input  logic [SCALE_W-1:0]     cfg_data_i
);

  localparam int unsigned RD_W = SAMPLE_BITS + $clog2(OVERSAMPLE_COUNT) - 2;

  logic            accept;
  logic            rd_push;
  logic [RD_W-1:0] reading;
  logic            rd_valid;
  logic [RD_W-1:0] rd_head;
  logic            rd_take;

  // Take a sample beat whenever the reading queue has room.
  assign accept = push && !full;

  ovar_front #(
    .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_i  (adc_sample_i),
    .rd_push_o (rd_push),
    .reading_o (reading)
  );

  // Hold finished readings so the byte side can stall on its own.
  ovar_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (RD_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rd_push),
    .data_i  (reading),
    .full_o  (full),
    .valid_o (rd_valid),
    .data_o  (rd_head),
    .take_i  (rd_take)
  );

  ovar_back #(
    .RD_W (RD_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .rd_valid_i (rd_valid),
    .reading_i  (rd_head),
    .rd_take_o  (rd_take),
    .empty      (empty),
    .pop        (pop),
    .out_char_o (out_char_o),
    .line_end_o (line_end_o)
  );

endmodule

### hw/rtl/ovar_front.sv
// Front end: sample accumulator that closes one oversampled reading per block.
module ovar_front #(
  parameter int unsigned OVERSAMPLE_COUNT = 16,
  parameter int unsigned SAMPLE_BITS      = 10,
  localparam int unsigned CNT_W = $clog2(OVERSAMPLE_COUNT),
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W,
  localparam int unsigned RD_W  = SUM_W - 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   rd_push_o,
  output logic [RD_W-1:0]        reading_o
);

  logic [SUM_W-1:0] sum_q, sum_d, sum_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;

  assign sum_next = sum_q + SUM_W'(sample_i);
  assign last     = (cnt_q == CNT_W'(OVERSAMPLE_COUNT - 1));

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // Close the block: drop the two low bits of the sum.
  assign rd_push_o = accept_i && last;
  assign reading_o = sum_next[SUM_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/ovar_fifo.sv
// Reading queue between front and back, with a registered head.
module ovar_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 12,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             take_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             head_valid_q;
  logic [WIDTH-1:0] head_q;
  logic             fill;

  // Refill the head when an entry is stored and it is free or taken.
  assign fill    = (cnt_q != '0) && (!head_valid_q || take_i);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = head_valid_q;
  assign data_o  = head_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !fill) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && fill) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= data_i;
    end
    if (fill) begin
      head_q <= mem[rptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q       <= '0;
      rptr_q       <= '0;
      cnt_q        <= '0;
      head_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (fill) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (fill) begin
        head_valid_q <= 1'b1;
      end else if (take_i) begin
        head_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/ovar_back.sv
// Back end: scale multiply, digit sequencer and output byte register.
module ovar_back
  import ovar_pkg::*;
#(
  parameter int unsigned RD_W = 12,
  localparam int unsigned PROD_W = RD_W + SCALE_W,
  localparam int unsigned RND_W  = PROD_W + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SCALE_W-1:0]  cfg_data_i,
  input  logic                rd_valid_i,
  input  logic [RD_W-1:0]     reading_i,
  output logic                rd_take_o,
  output logic                empty,
  input  logic                pop,
  output logic [CHAR_W-1:0]   out_char_o,
  output logic                line_end_o
);

  logic [SCALE_W-1:0] scale_q;

  logic               mul_valid_q;
  logic [PROD_W-1:0]  prod_q;

  logic               seq_active_q;
  slot_e              slot_q;
  logic [HUND_W-1:0]  rem_q, rem_d;
  logic               seq_load;

  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               line_end_q;
  logic               out_adv;

  logic [RND_W-1:0]   rounded;
  logic [HUND_W-1:0]  hund;

  logic [27:0]        th_prod;
  logic [15:0]        hu_prod;
  logic [14:0]        te_prod;
  logic [3:0]         digit;

  assign out_adv   = !out_valid_q || pop;
  assign seq_load  = mul_valid_q && !seq_active_q;
  assign rd_take_o = rd_valid_i && (!mul_valid_q || seq_load);

  // Round the product to whole hundredths and clamp at 99.99.
  assign rounded = (RND_W'(prod_q) + RND_W'(ROUND_HALF)) >> FRAC_BITS;
  assign hund    = (rounded > RND_W'(MAX_HUNDREDTHS)) ? MAX_HUNDREDTHS : HUND_W'(rounded);

  assign th_prod = 28'(rem_q) * 28'(RECIP_1000);
  assign hu_prod = 16'(rem_q[9:0]) * 16'(RECIP_100);
  assign te_prod = 15'(rem_q[6:0]) * 15'(RECIP_10);

  // Peel one decimal digit per byte off the remaining hundredths.
  always_comb begin
    digit      = '0;
    rem_d      = rem_q;
    char_d     = CHAR_ZERO;
    case (slot_q)
      SLOT_TENS: begin
        digit  = th_prod[26:23];
        rem_d  = rem_q - HUND_W'(digit) * HUND_W'(1000);
        char_d = CHAR_ZERO + CHAR_W'(digit);
      end
      SLOT_ONES: begin
        digit  = hu_prod[15:12];
        rem_d  = rem_q - HUND_W'(digit) * HUND_W'(100);
        char_d = CHAR_ZERO + CHAR_W'(digit);
      end
      SLOT_POINT: begin
        char_d = CHAR_POINT;
      end
      SLOT_TENTHS: begin
        digit  = te_prod[14:11];
        rem_d  = rem_q - HUND_W'(digit) * HUND_W'(10);
        char_d = CHAR_ZERO + CHAR_W'(digit);
      end
      SLOT_HUNDREDTHS: begin
        char_d = CHAR_ZERO + CHAR_W'(rem_q[3:0]);
      end
      SLOT_CR: begin
        char_d = CHAR_CR;
      end
      SLOT_LF: begin
        char_d = CHAR_LF;
      end
      default: begin
        char_d = CHAR_ZERO;
      end
    endcase
  end

  assign empty      = !out_valid_q;
  assign out_char_o = char_q;
  assign line_end_o = line_end_q;

  always_ff @(posedge clk_i) begin
    if (rd_take_o) begin
      prod_q <= PROD_W'(reading_i) * PROD_W'(scale_q);
    end
    if (seq_load) begin
      rem_q <= hund;
    end else if (seq_active_q && out_adv) begin
      rem_q <= rem_d;
    end
    if (seq_active_q && out_adv) begin
      char_q     <= char_d;
      line_end_q <= (slot_q == SLOT_LF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= SCALE_RESET;
      mul_valid_q  <= 1'b0;
      seq_active_q <= 1'b0;
      slot_q       <= SLOT_TENS;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
      if (rd_take_o) begin
        mul_valid_q <= 1'b1;
      end else if (seq_load) begin
        mul_valid_q <= 1'b0;
      end
      if (seq_load) begin
        seq_active_q <= 1'b1;
        slot_q       <= SLOT_TENS;
      end else if (seq_active_q && out_adv) begin
        if (slot_q == SLOT_LF) begin
          seq_active_q <= 1'b0;
        end else begin
          slot_q <= slot_e'(slot_q + 3'd1);
        end
      end
      if (out_adv) begin
        out_valid_q <= seq_active_q;
      end
    end
  end

endmodule
